[src/twus_pkg.sv]
// Package for the tile word unpack / scatter block.
// Holds widths, limits, register indexes, controller state type and the
// command / status structs shared by the controller, datapath and top level.
package twus_pkg;

   // Limits of the tile geometry
   localparam int TILE_DIM_MAX = 4096;
   localparam int LEVELS_MAX   = 256;

   // Channel widths
   localparam int REQ_DATA_W = 40;   // data_byte, tile_col, tile_row
   localparam int RSP_DATA_W = 184;  // 177 field bits padded to whole bytes
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // Field widths
   localparam int POS_W   = 13;   // in-tile column / row and tile sizes
   localparam int LEV_W   = 9;    // level counter, stops at LEVELS_MAX
   localparam int GXY_W   = 30;   // tile index times tile size plus offset
   localparam int ADDR_W  = 40;
   localparam int RAW_W   = 33;
   localparam int SCL_W   = 64;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_WORD_BYTES   = 3'd0,
      REG_WORD_FORMAT  = 3'd1,
      REG_TILE_WIDTH   = 3'd2,
      REG_TILE_HEIGHT  = 3'd3,
      REG_BORDER_WIDTH = 3'd4,
      REG_GRID_WIDTH   = 3'd5,
      REG_GRID_HEIGHT  = 3'd6,
      REG_SCALE_Q16    = 3'd7
   } csr_index_type;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,   // take bytes; a word-completing byte starts the sequence
      ST_PROD,   // global position, scale and level products
      ST_SUM,    // grid bound check, level row plus global row
      ST_ADDR,   // row index times grid width
      ST_EMIT    // final add, load result register
   } ctrl_state_type;

   // Controller to datapath
   typedef struct packed {
      logic accept;    // input transaction this cycle
      logic prod;
      logic sum;
      logic addr;
      logic load;      // load result register
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic word_done; // byte on the input completes a word
      logic keep;      // current word gives a result
      logic out_free;  // result register can take a new transaction
   } dp_status_type;

endpackage

[src/twus_ctrl.sv]
// Controller state machine of the tile word unpack / scatter block.
// Depends on twus_pkg; drives datapath commands from its status.
module twus_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  twus_pkg::dp_status_type status,
   output twus_pkg::dp_cmd_type    cmd
);
   import twus_pkg::*;

   ctrl_state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && status.word_done) state_in = ST_PROD;
         end
         ST_PROD: state_in = ST_SUM;
         ST_SUM:  state_in = ST_ADDR;
         ST_ADDR: state_in = ST_EMIT;
         ST_EMIT: begin
            if (!status.keep || status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
         end
         ST_PROD: cmd.prod = 1'b1;
         ST_SUM:  cmd.sum  = 1'b1;
         ST_ADDR: cmd.addr = 1'b1;
         ST_EMIT: cmd.load = status.keep && status.out_free;
         default: cmd = '0;
      endcase
   end

endmodule

[src/twus_dp.sv]
// Datapath of the tile word unpack / scatter block: configuration registers,
// word assembly, in-tile position counters, address and scale arithmetic,
// result register. Depends on twus_pkg; sequenced by twus_ctrl.
module twus_dp (
   input  logic                                clock,
   input  logic                                reset,
   // configuration write port
   input  logic                                csr_we,
   input  logic [twus_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [twus_pkg::CSR_DATA_W-1:0]     csr_wdata,
   // input payload
   input  logic [twus_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                                req_tuser,
   // result channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [twus_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // control
   input  twus_pkg::dp_cmd_type                 cmd,
   output twus_pkg::dp_status_type              status
);
   import twus_pkg::*;

   // Configuration registers
   logic [2:0]               word_bytes_ff;
   logic [1:0]               word_format_ff;
   logic [POS_W-1:0]         tile_width_ff, tile_height_ff;
   logic [3:0]               border_width_ff;
   logic [15:0]              grid_width_ff, grid_height_ff;
   logic signed [31:0]       scale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         word_bytes_ff   <= 3'd1;
         word_format_ff  <= 2'd0;
         tile_width_ff   <= 13'd1;
         tile_height_ff  <= 13'd1;
         border_width_ff <= 4'd3;
         grid_width_ff   <= 16'd1;
         grid_height_ff  <= 16'd1;
         scale_ff        <= 32'sd65536;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            REG_WORD_BYTES:   word_bytes_ff   <= csr_wdata[2:0];
            REG_WORD_FORMAT:  word_format_ff  <= csr_wdata[1:0];
            REG_TILE_WIDTH:   tile_width_ff   <= csr_wdata[12:0];
            REG_TILE_HEIGHT:  tile_height_ff  <= csr_wdata[12:0];
            REG_BORDER_WIDTH: border_width_ff <= csr_wdata[3:0];
            REG_GRID_WIDTH:   grid_width_ff   <= csr_wdata[15:0];
            REG_GRID_HEIGHT:  grid_height_ff  <= csr_wdata[15:0];
            REG_SCALE_Q16:    scale_ff        <= $signed(csr_wdata);
            default:          ;
         endcase
      end
   end

   // Effective (clamped) configuration
   logic [2:0]       wb_eff;
   logic [POS_W-1:0] tw_eff, th_eff, tnx, tny;
   logic             little_fmt, signed_fmt;

   always_comb begin
      if (word_bytes_ff == 3'd0)      wb_eff = 3'd1;
      else if (word_bytes_ff > 3'd4)  wb_eff = 3'd4;
      else                            wb_eff = word_bytes_ff;

      if (tile_width_ff == '0)                         tw_eff = 13'd1;
      else if (tile_width_ff > POS_W'(TILE_DIM_MAX))   tw_eff = POS_W'(TILE_DIM_MAX);
      else                                             tw_eff = tile_width_ff;

      if (tile_height_ff == '0)                        th_eff = 13'd1;
      else if (tile_height_ff > POS_W'(TILE_DIM_MAX))  th_eff = POS_W'(TILE_DIM_MAX);
      else                                             th_eff = tile_height_ff;

      tnx        = tw_eff + {8'b0, border_width_ff, 1'b0};
      tny        = th_eff + {8'b0, border_width_ff, 1'b0};
      little_fmt = word_format_ff[0];
      signed_fmt = word_format_ff[1];
   end

   // Unpack input payload
   logic [7:0]  data_byte;
   logic [15:0] tile_col, tile_row;
   assign data_byte = req_tdata[7:0];
   assign tile_col  = req_tdata[23:8];
   assign tile_row  = req_tdata[39:24];

   // In-tile state
   logic [1:0]       byte_phase_ff, byte_phase_in;
   logic [23:0]      partial_ff, partial_in;
   logic [POS_W-1:0] col_ff, col_in, row_ff, row_in;
   logic [LEV_W-1:0] lev_ff, lev_in;

   // Tile start clears position before the byte is taken
   logic [1:0]       eff_phase;
   logic [23:0]      eff_partial;
   logic [POS_W-1:0] eff_col, eff_row;
   logic [LEV_W-1:0] eff_lev;
   assign eff_phase   = req_tuser ? 2'd0  : byte_phase_ff;
   assign eff_partial = req_tuser ? 24'd0 : partial_ff;
   assign eff_col     = req_tuser ? '0    : col_ff;
   assign eff_row     = req_tuser ? '0    : row_ff;
   assign eff_lev     = req_tuser ? '0    : lev_ff;

   logic word_done;
   assign word_done = ({1'b0, eff_phase} + 3'd1) >= wb_eff;

   // Word assembly
   logic [1:0]  wb_m1;
   logic [31:0] word_full;
   logic [RAW_W-1:0] raw_in;

   always_comb begin
      wb_m1 = 2'(wb_eff - 3'd1);
      if (little_fmt) begin
         word_full = {8'b0, eff_partial} | ({24'b0, data_byte} << {wb_m1, 3'b000});
      end else begin
         word_full = {eff_partial, data_byte};
      end
      // mask to word size and sign extend when signed
      unique case (wb_eff)
         3'd1: begin
            raw_in = {{25{signed_fmt & word_full[7]}}, word_full[7:0]};
         end
         3'd2: begin
            raw_in = {{17{signed_fmt & word_full[15]}}, word_full[15:0]};
         end
         3'd3: begin
            raw_in = {{9{signed_fmt & word_full[23]}}, word_full[23:0]};
         end
         default: begin
            raw_in = {signed_fmt & word_full[31], word_full};
         end
      endcase
   end

   // Partial word and position update
   logic [POS_W-1:0] col_inc, row_inc;
   always_comb begin
      byte_phase_in = eff_phase;
      partial_in    = eff_partial;
      col_in        = eff_col;
      row_in        = eff_row;
      lev_in        = eff_lev;
      col_inc       = eff_col + 13'd1;
      row_inc       = eff_row + 13'd1;
      if (!word_done) begin
         if (little_fmt) begin
            partial_in = 24'({8'b0, eff_partial} | ({24'b0, data_byte} << {eff_phase, 3'b000}));
         end else begin
            partial_in = {eff_partial[15:0], data_byte};
         end
         byte_phase_in = eff_phase + 2'd1;
      end else begin
         byte_phase_in = 2'd0;
         partial_in    = 24'd0;
         if (eff_lev < LEV_W'(LEVELS_MAX)) begin
            if (col_inc >= tnx) begin
               col_in = '0;
               if (row_inc >= tny) begin
                  row_in = '0;
                  lev_in = eff_lev + 9'd1;
               end else begin
                  row_in = row_inc;
               end
            end else begin
               col_in = col_inc;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_phase_ff <= 2'd0;
         partial_ff    <= 24'd0;
         col_ff        <= '0;
         row_ff        <= '0;
         lev_ff        <= '0;
      end else if (cmd.accept) begin
         byte_phase_ff <= byte_phase_in;
         partial_ff    <= partial_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         lev_ff        <= lev_in;
      end
   end

   // Word capture at the completing byte
   logic [4:0]            bdr_hi;
   logic                  inner_ok_in;
   logic signed [RAW_W-1:0] raw_ff;
   logic [POS_W-1:0]      cap_col_ff, cap_row_ff;
   logic [7:0]            cap_lev_ff;
   logic [15:0]           tcol_ff, trow_ff;
   logic                  inner_ok_ff;

   always_comb begin
      bdr_hi      = {1'b0, border_width_ff};
      inner_ok_in = (eff_lev < LEV_W'(LEVELS_MAX))
                 && (eff_col >= {8'b0, bdr_hi})
                 && (eff_col <  tw_eff + {9'b0, border_width_ff})
                 && (eff_row >= {8'b0, bdr_hi})
                 && (eff_row <  th_eff + {9'b0, border_width_ff});
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && word_done) begin
         raw_ff      <= $signed(raw_in);
         cap_col_ff  <= eff_col;
         cap_row_ff  <= eff_row;
         cap_lev_ff  <= eff_lev[7:0];
         tcol_ff     <= tile_col;
         trow_ff     <= tile_row;
         inner_ok_ff <= inner_ok_in;
      end
   end

   // Stage: global position, scale and level products
   logic [GXY_W-1:0]        gx_ff, gy_ff;
   logic [GXY_W-1:0]        gx_in, gy_in;
   logic [POS_W-1:0]        col_off, row_off;
   logic signed [SCL_W-1:0] scaled_ff, scaled_in;
   logic [23:0]             levgh_ff;

   always_comb begin
      col_off   = cap_col_ff - {9'b0, border_width_ff};
      row_off   = cap_row_ff - {9'b0, border_width_ff};
      gx_in     = GXY_W'({14'b0, tcol_ff} * {17'b0, tw_eff}) + {17'b0, col_off};
      gy_in     = GXY_W'({14'b0, trow_ff} * {17'b0, th_eff}) + {17'b0, row_off};
      scaled_in = raw_ff * scale_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.prod) begin
         gx_ff     <= gx_in;
         gy_ff     <= gy_in;
         scaled_ff <= scaled_in;
         levgh_ff  <= {16'b0, cap_lev_ff} * {8'b0, grid_height_ff};
      end
   end

   // Stage: grid bounds and row index
   logic        keep_ff;
   logic [24:0] row_lin_ff;

   always_ff @(posedge clock) begin
      if (cmd.sum) begin
         keep_ff    <= inner_ok_ff
                    && (gx_ff < {14'b0, grid_width_ff})
                    && (gy_ff < {14'b0, grid_height_ff});
         row_lin_ff <= {1'b0, levgh_ff} + {9'b0, gy_ff[15:0]};
      end
   end

   // Stage: row index times grid width
   logic [ADDR_W-1:0] addr_prod_ff;

   always_ff @(posedge clock) begin
      if (cmd.addr) begin
         addr_prod_ff <= ADDR_W'({15'b0, row_lin_ff} * {24'b0, grid_width_ff});
      end
   end

   // Result register
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [ADDR_W-1:0]     addr_final;

   assign addr_final = addr_prod_ff + {24'b0, gx_ff[15:0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_data_ff <= {7'b0, scaled_ff, raw_ff, cap_lev_ff,
                         gy_ff[15:0], gx_ff[15:0], addr_final};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Status to controller
   assign status.word_done = word_done;
   assign status.keep      = keep_ff;
   assign status.out_free  = !rsp_valid_ff || rsp_tready;

endmodule

[src/tile_word_unpack_scatter_core.sv]
// A byte that does not complete a word is taken with the controller idle; a
// byte that completes a word holds the input through the accept and four steps
// of the controller (position, bound and address multipliers), and longer while
// a kept word waits in ST_EMIT for the result register. Throughput: one byte per
// cycle inside a word; no new word starts before the steps end. A kept word shows
// on rsp_tvalid once ST_EMIT loads it. Reset is synchronous, active high; it
// restores the register defaults and clears the in-tile position and result valid.
module tile_word_unpack_scatter_core (
   input  logic                               clock,
   input  logic                               reset,
   // input channel
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [twus_pkg::REQ_DATA_W-1:0]    req_tdata,  // data_byte, tile_col, tile_row
   input  logic                               req_tuser,  // tile_start
   // result channel
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // linear_address, global_x, global_y, level, raw_value, scaled_value, zero pad
   output logic [twus_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // configuration write port
   input  logic                               csr_we,
   input  logic [twus_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [twus_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import twus_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   twus_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   twus_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

[src/twus_chk.sv]
// Port-level checker for the tile word unpack / scatter block.
// Depends on twus_pkg; attached to the top level by the bind at the end.
module twus_chk (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [twus_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import twus_pkg::*;

   // Stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // Pad bits stay zero
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_DATA_W-1:177] == '0)
      else $error("pad bits of result not zero");

   // Address includes the column offset and never wraps
   a_addr_ge_x: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[39:0] >= {24'b0, rsp_tdata[55:40]})
      else $error("linear address below global column");

   // Input stalls only after a transaction
   a_ready_fall: assert property (@(posedge clock) disable iff (reset)
      $fell(req_tready) |-> $past(req_tvalid && req_tready))
      else $error("input stalled without a transaction");

   // A fresh result follows an input transaction
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 5))
      else $error("result without a matching input transaction");

endmodule

bind tile_word_unpack_scatter_core twus_chk u_chk (.*);
